### design/frame_nearest_color_classifier_defines.svh
// Assertion macros used by the top-level design file.
`ifndef FRAME_NEAREST_COLOR_CLASSIFIER_DEFINES_SVH
`define FRAME_NEAREST_COLOR_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CHK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CHK(label, prop)
`define ASSERT_ANY(label, prop)
`endif

`endif

### design/fncc_pkg.sv
package fncc_pkg;

  localparam int DIM_BITS   = 10;
  localparam int PIXEL_W    = 16;
  localparam int R_W        = 5;
  localparam int G_W        = 6;
  localparam int B_W        = 5;
  localparam int SUMR_W     = 9;
  localparam int SUMG_W     = 10;
  localparam int SUMB_W     = 9;
  localparam int CLASS_W    = 4;
  localparam int NUM_COLORS = 9;
  localparam int DIST_W     = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(240);
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(320);

  // floor(x / 9) == (x * 7282) >> 16 for every x below 1024.
  localparam int DIV9_W     = 13;
  localparam int DIV9_SHIFT = 16;
  localparam logic [DIV9_W-1:0] DIV9_MUL = DIV9_W'(7282);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_HEIGHT = 1'b0,
    REG_FRAME_WIDTH  = 1'b1
  } cfg_reg_t;

  localparam logic [R_W-1:0] PAL_R [NUM_COLORS] = '{
    5'd31, 5'd31, 5'd31, 5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd31};
  localparam logic [G_W-1:0] PAL_G [NUM_COLORS] = '{
    6'd0, 6'd41, 6'd63, 6'd63, 6'd63, 6'd0, 6'd0, 6'd0, 6'd63};
  localparam logic [B_W-1:0] PAL_B [NUM_COLORS] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd31, 5'd31, 5'd31, 5'd0, 5'd31};

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] color_class;
    logic [R_W-1:0]     avg_red;
    logic [G_W-1:0]     avg_green;
    logic [B_W-1:0]     avg_blue;
  } result_item_t;

  typedef struct packed {
    logic [SUMR_W-1:0] red_sum;
    logic [SUMG_W-1:0] green_sum;
    logic [SUMB_W-1:0] blue_sum;
  } sums_t;

  typedef struct packed {
    logic [R_W-1:0] avg_red;
    logic [G_W-1:0] avg_green;
    logic [B_W-1:0] avg_blue;
  } avg_t;

  typedef logic [DIST_W-1:0] dist_t;

  // True when pos is at one quarter, one half or three quarters of size.
  function automatic logic is_grid(input logic [DIM_BITS-1:0] pos,
                                   input logic [DIM_BITS-1:0] size);
    logic [DIM_BITS+1:0] three;
    three = {2'b00, size} + {1'b0, size, 1'b0};
    return (pos == (size >> 2)) || (pos == (size >> 1)) ||
           ({2'b00, pos} == (three >> 2));
  endfunction

endpackage

### design/fncc_scan.sv
module fncc_scan
  import fncc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  pixel_item_t           in_item,
  output logic                  in_stall,
  output logic                  out_valid,
  output sums_t                 out_sums,
  input  logic                  out_stall
);

  logic [DIM_BITS-1:0] frame_height;
  logic [DIM_BITS-1:0] frame_width;
  logic [DIM_BITS-1:0] row_count;
  logic [DIM_BITS-1:0] col_count;
  sums_t               sums;

  logic [DIM_BITS-1:0] row_cur;
  logic [DIM_BITS-1:0] col_cur;
  sums_t               sums_cur;
  sums_t               sums_next;
  logic                hit;
  logic                row_end;
  logic                frame_end;
  logic                accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    row_cur   = in_item.frame_start ? '0 : row_count;
    col_cur   = in_item.frame_start ? '0 : col_count;
    sums_cur  = in_item.frame_start ? '0 : sums;
    hit       = is_grid(row_cur, frame_height) && is_grid(col_cur, frame_width);
    sums_next = sums_cur;
    if (hit) begin
      sums_next.red_sum   = sums_cur.red_sum + SUMR_W'(in_item.pixel[15:11]);
      sums_next.green_sum = sums_cur.green_sum + SUMG_W'(in_item.pixel[10:5]);
      sums_next.blue_sum  = sums_cur.blue_sum + SUMB_W'(in_item.pixel[4:0]);
    end
    row_end   = ({1'b0, col_cur} + 1'b1) >= {1'b0, frame_width};
    frame_end = row_end && (({1'b0, row_cur} + 1'b1) >= {1'b0, frame_height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_height <= HEIGHT_RESET;
      frame_width  <= WIDTH_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_HEIGHT: frame_height <= DIM_BITS'(cfg_data);
        REG_FRAME_WIDTH:  frame_width  <= DIM_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      sums      <= '0;
    end else if (accept) begin
      if (frame_end) begin
        row_count <= '0;
        col_count <= '0;
        sums      <= '0;
      end else if (row_end) begin
        row_count <= row_cur + 1'b1;
        col_count <= '0;
        sums      <= sums_next;
      end else begin
        row_count <= row_cur;
        col_count <= col_cur + 1'b1;
        sums      <= sums_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= accept && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_sums <= sums_next;
    end
  end

endmodule

### design/fncc_avg.sv
module fncc_avg
  import fncc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  sums_t in_sums,
  output logic  in_stall,
  output logic  out_valid,
  output avg_t  out_avg,
  input  logic  out_stall
);

  logic [SUMR_W+DIV9_W-1:0] prod_r;
  logic [SUMG_W+DIV9_W-1:0] prod_g;
  logic [SUMB_W+DIV9_W-1:0] prod_b;
  avg_t                     avg_next;

  assign in_stall = out_valid && out_stall;

  always_comb begin
    prod_r = (SUMR_W+DIV9_W)'(in_sums.red_sum) * (SUMR_W+DIV9_W)'(DIV9_MUL);
    prod_g = (SUMG_W+DIV9_W)'(in_sums.green_sum) * (SUMG_W+DIV9_W)'(DIV9_MUL);
    prod_b = (SUMB_W+DIV9_W)'(in_sums.blue_sum) * (SUMB_W+DIV9_W)'(DIV9_MUL);
    avg_next.avg_red   = prod_r[DIV9_SHIFT +: R_W];
    avg_next.avg_green = prod_g[DIV9_SHIFT +: G_W];
    avg_next.avg_blue  = prod_b[DIV9_SHIFT +: B_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_avg <= avg_next;
    end
  end

endmodule

### design/fncc_match.sv
module fncc_match
  import fncc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  avg_t         in_avg,
  output logic         in_stall,
  output logic         out_valid,
  output result_item_t out_item,
  input  logic         out_stall
);

  logic  dist_valid;
  avg_t  dist_avg;
  dist_t sq_dist [NUM_COLORS];
  dist_t dist_next [NUM_COLORS];
  logic  dist_stall;

  logic [R_W-1:0]     dr;
  logic [G_W-1:0]     dg;
  logic [B_W-1:0]     db;
  dist_t              best_dist;
  logic [CLASS_W-1:0] best;

  assign dist_stall = dist_valid && out_valid && out_stall;
  assign in_stall   = dist_stall;

  always_comb begin
    for (int m = 0; m < NUM_COLORS; m++) begin
      dr = (in_avg.avg_red >= PAL_R[m]) ? in_avg.avg_red - PAL_R[m]
                                        : PAL_R[m] - in_avg.avg_red;
      dg = (in_avg.avg_green >= PAL_G[m]) ? in_avg.avg_green - PAL_G[m]
                                          : PAL_G[m] - in_avg.avg_green;
      db = (in_avg.avg_blue >= PAL_B[m]) ? in_avg.avg_blue - PAL_B[m]
                                         : PAL_B[m] - in_avg.avg_blue;
      dist_next[m] = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dg) * DIST_W'(dg) +
                     DIST_W'(db) * DIST_W'(db);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (!dist_stall) begin
      dist_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!dist_stall) begin
      dist_avg <= in_avg;
      sq_dist  <= dist_next;
    end
  end

  // Strict compare keeps the earlier palette entry on a tie.
  always_comb begin
    best_dist = sq_dist[0];
    best      = '0;
    for (int m = 1; m < NUM_COLORS; m++) begin
      if (sq_dist[m] < best_dist) begin
        best_dist = sq_dist[m];
        best      = CLASS_W'(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_item.color_class <= best;
      out_item.avg_red     <= dist_avg.avg_red;
      out_item.avg_green   <= dist_avg.avg_green;
      out_item.avg_blue    <= dist_avg.avg_blue;
    end
  end

endmodule

### design/frame_nearest_color_classifier.sv
// Takes one RGB565 pixel per cycle in raster order and, on the last pixel of
// each frame, reports the mean color of nine grid samples and the nearest of
// nine palette colors. The result passes through a scan stage, a
// divide-by-nine stage, a distance stage and a nearest-color stage. Pixels
// stall only while a finished result waits at the output and the stages
// behind it are full. The user must write frame height and width through
// the configuration port while no frame is in flight (not enforced).
`include "frame_nearest_color_classifier_defines.svh"

module frame_nearest_color_classifier
  import fncc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  pixel_valid,
  input  pixel_item_t           pixel_item,
  output logic                  pixel_stall,
  output logic                  result_valid,
  output result_item_t          result_item,
  input  logic                  result_stall
);

  logic  sums_valid;
  sums_t sums;
  logic  sums_stall;
  logic  avg_valid;
  avg_t  avg;
  logic  avg_stall;

  fncc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (pixel_valid),
    .in_item   (pixel_item),
    .in_stall  (pixel_stall),
    .out_valid (sums_valid),
    .out_sums  (sums),
    .out_stall (sums_stall)
  );

  fncc_avg u_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sums_valid),
    .in_sums   (sums),
    .in_stall  (sums_stall),
    .out_valid (avg_valid),
    .out_avg   (avg),
    .out_stall (avg_stall)
  );

  fncc_match u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (avg_valid),
    .in_avg    (avg),
    .in_stall  (avg_stall),
    .out_valid (result_valid),
    .out_item  (result_item),
    .out_stall (result_stall)
  );

  `ASSERT_ANY(a_no_result_after_reset, rst |=> !result_valid)
  `ASSERT_CHK(a_stall_only_when_backed_up, pixel_stall |-> (result_valid && result_stall))
  `ASSERT_CHK(a_class_in_range, result_valid |-> (result_item.color_class < CLASS_W'(NUM_COLORS)))
  `ASSERT_CHK(a_sums_pass_through, (sums_valid && !sums_stall) |=> avg_valid)

endmodule
